FILE: hw/rtl/qstb_pkg.sv
// ----------------------------------------------------------------------------
// Quad span table builder package
// Shared constants and item types.
// ----------------------------------------------------------------------------
package qstb_pkg;

  localparam int unsigned CoordBits   = 12;
  localparam int unsigned DefMaxRows  = 64;
  localparam int unsigned OffsetBits  = 6;

  typedef struct packed {
    logic signed [CoordBits-1:0] bl_x;
    logic signed [CoordBits-1:0] bl_y;
    logic signed [CoordBits-1:0] tl_x;
    logic signed [CoordBits-1:0] tl_y;
    logic signed [CoordBits-1:0] tr_x;
    logic signed [CoordBits-1:0] tr_y;
    logic signed [CoordBits-1:0] br_x;
    logic signed [CoordBits-1:0] br_y;
  } quad_t;

  typedef struct packed {
    logic [OffsetBits-1:0]       row_offset;
    logic signed [CoordBits-1:0] row_y;
    logic signed [CoordBits-1:0] span_left;
    logic signed [CoordBits-1:0] span_right;
    logic                        last_row;
    logic                        too_tall;
  } span_t;

endpackage

FILE: hw/rtl/quad_span_table_builder_top.sv
// ----------------------------------------------------------------------------
// Quad span table builder
// Builds per-row x spans of a quadrilateral by Bresenham edge walks.
// ----------------------------------------------------------------------------
// Usage: the quad channel (quad, quad_valid, quad_stall) takes one item with
// four corners. The block stalls new items until every span item of the
// current quad has been taken on the span channel (span, span_valid,
// span_stall). One span item is sent per row from min y upward, the final
// one with last_row set. A quad taller than MAX_ROWS gives one item with
// too_tall set.
// Sequence: the span memory is cleared row by row, then each edge walk
// reads and then writes the span memory entry of every visited pixel, a
// read-modify-write through the registered memory read, and readout
// then reads the rows one by one (states S_ORD, S_OWAIT, S_OUT).
// Reset returns the controller to idle; the span memory is not cleared.
// When the receiver stalls, the span item holds and readout waits.
// ----------------------------------------------------------------------------
module quad_span_table_builder_top import qstb_pkg::*; #(
  parameter int unsigned MAX_ROWS = DefMaxRows
) (
  input  logic  clk,
  input  logic  rst,
  input  quad_t quad,
  input  logic  quad_valid,
  output logic  quad_stall,
  output span_t span,
  output logic  span_valid,
  input  logic  span_stall
);

  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned CW = CoordBits;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CLEAR = 8'b00000010,
    S_SETUP = 8'b00000100,
    S_RD    = 8'b00001000,
    S_WR    = 8'b00010000,
    S_ORD   = 8'b00100000,
    S_OWAIT = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  quad_t  q;
  logic signed [CW:0]   min_y, max_y;
  logic [AW:0]          rows;
  logic [AW:0]          idx;
  logic [1:0]           edge_num;
  logic signed [CW:0]   wx, wy, x1, y1, dx, dy;
  logic signed [CW+2:0] werr;
  logic                 sx, sy;

  logic                 mwe;
  logic [AW-1:0]        mwaddr, mraddr;
  logic signed [CW-1:0] mwl, mwr, mrl, mrr;

  logic signed [CW-1:0] cx [4];
  logic signed [CW-1:0] cy [4];
  logic signed [CW:0]   mn, mx, ht, row_rel;
  logic signed [CW+3:0] e2;
  logic                 row_ok;

  always_comb begin
    cx[0] = q.bl_x; cy[0] = q.bl_y;
    cx[1] = q.tl_x; cy[1] = q.tl_y;
    cx[2] = q.tr_x; cy[2] = q.tr_y;
    cx[3] = q.br_x; cy[3] = q.br_y;
    mn = (CW+1)'(cy[0]);
    mx = (CW+1)'(cy[0]);
    for (int i = 1; i < 4; i++) begin
      if ((CW+1)'(cy[i]) < mn) mn = (CW+1)'(cy[i]);
      if ((CW+1)'(cy[i]) > mx) mx = (CW+1)'(cy[i]);
    end
    ht = max_y - min_y + (CW+1)'(1);
    row_rel = wy - min_y;
    row_ok = (row_rel >= 0) && (row_rel < (CW+1)'(MAX_ROWS));
    e2 = {werr, 1'b0};
  end

  qstb_span_mem #(.MAX_ROWS(MAX_ROWS)) u_mem (
    .clk    (clk),
    .we     (mwe),
    .waddr  (mwaddr),
    .wleft  (mwl),
    .wright (mwr),
    .raddr  (mraddr),
    .rleft  (mrl),
    .rright (mrr)
  );

  always_comb begin
    mwe    = 1'b0;
    mwaddr = idx[AW-1:0];
    mwl    = {1'b0, {(CW-1){1'b1}}};
    mwr    = {1'b1, {(CW-1){1'b0}}};
    mraddr = idx[AW-1:0];
    if (state == S_CLEAR) begin
      mwe = 1'b1;
    end else if (state == S_WR) begin
      mwe    = row_ok;
      mwaddr = row_rel[AW-1:0];
      mwl    = ($signed(wx[CW-1:0]) < mrl) ? $signed(wx[CW-1:0]) : mrl;
      mwr    = ($signed(wx[CW-1:0]) > mrr) ? $signed(wx[CW-1:0]) : mrr;
    end
    if (state == S_RD) begin
      mraddr = row_rel[AW-1:0];
    end
  end

  assign quad_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      span_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (quad_valid) begin
            q     <= quad;
            state <= S_SETUP;
            idx   <= '0;
            edge_num <= 2'd0;
            rows  <= '0;
          end
        end
        S_SETUP: begin
          // First pass computes the box, the second checks the height and starts the clear, later passes load an edge.
          if (rows == '0 && edge_num == 2'd0 && idx == '0) begin
            min_y <= mn;
            max_y <= mx;
            rows  <= '1;
          end else if (rows == '1 && idx == '0 && edge_num == 2'd0 && !span_valid
                       && state == S_SETUP && max_y - min_y >= (CW+1)'(MAX_ROWS)) begin
            span.row_offset <= '0;
            span.row_y      <= min_y[CW-1:0];
            span.span_left  <= '0;
            span.span_right <= '0;
            span.last_row   <= 1'b1;
            span.too_tall   <= 1'b1;
            span_valid      <= 1'b1;
            state           <= S_OUT;
            rows            <= '0;
          end else if (rows == '1) begin
            rows  <= ht[AW:0];
            idx   <= '0;
            state <= S_CLEAR;
          end else begin
            wx   <= (CW+1)'(cx[edge_num]);
            wy   <= (CW+1)'(cy[edge_num]);
            x1   <= (CW+1)'(cx[edge_num + 2'd1]);
            y1   <= (CW+1)'(cy[edge_num + 2'd1]);
            dx   <= (cx[edge_num+2'd1] > cx[edge_num]) ?
                    (CW+1)'(cx[edge_num+2'd1]) - (CW+1)'(cx[edge_num]) :
                    (CW+1)'(cx[edge_num]) - (CW+1)'(cx[edge_num+2'd1]);
            dy   <= (cy[edge_num+2'd1] > cy[edge_num]) ?
                    (CW+1)'(cy[edge_num+2'd1]) - (CW+1)'(cy[edge_num]) :
                    (CW+1)'(cy[edge_num]) - (CW+1)'(cy[edge_num+2'd1]);
            sx   <= cx[edge_num] < cx[edge_num+2'd1];
            sy   <= cy[edge_num] < cy[edge_num+2'd1];
            werr <= (CW+3)'(((cx[edge_num+2'd1] > cx[edge_num]) ?
                    (CW+1)'(cx[edge_num+2'd1]) - (CW+1)'(cx[edge_num]) :
                    (CW+1)'(cx[edge_num]) - (CW+1)'(cx[edge_num+2'd1])))
                  - (CW+3)'(((cy[edge_num+2'd1] > cy[edge_num]) ?
                    (CW+1)'(cy[edge_num+2'd1]) - (CW+1)'(cy[edge_num]) :
                    (CW+1)'(cy[edge_num]) - (CW+1)'(cy[edge_num+2'd1])));
            state <= S_RD;
          end
        end
        S_CLEAR: begin
          if (idx + (AW+1)'(1) == rows) begin
            idx   <= '1;
            state <= S_SETUP;
          end else begin
            idx <= idx + (AW+1)'(1);
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (wx == x1 && wy == y1) begin
            edge_num <= edge_num + 2'd1;
            if (edge_num == 2'd3) begin
              idx   <= '0;
              state <= S_ORD;
            end else begin
              state <= S_SETUP;
            end
          end else begin
            state <= S_RD;
            if (e2 > -(CW+4)'(dy) && e2 < (CW+4)'(dx)) begin
              werr <= werr - (CW+3)'(dy) + (CW+3)'(dx);
            end else if (e2 > -(CW+4)'(dy)) begin
              werr <= werr - (CW+3)'(dy);
            end else if (e2 < (CW+4)'(dx)) begin
              werr <= werr + (CW+3)'(dx);
            end
            if (e2 > -(CW+4)'(dy)) wx <= sx ? wx + (CW+1)'(1) : wx - (CW+1)'(1);
            if (e2 < (CW+4)'(dx))  wy <= sy ? wy + (CW+1)'(1) : wy - (CW+1)'(1);
          end
        end
        S_ORD: begin
          state <= S_OWAIT;
        end
        S_OWAIT: begin
          span.row_offset <= OffsetBits'(idx);
          span.row_y      <= CW'(min_y + (CW+1)'(idx));
          span.span_left  <= mrl;
          span.span_right <= mrr;
          span.last_row   <= (idx + (AW+1)'(1) == rows);
          span.too_tall   <= 1'b0;
          span_valid      <= 1'b1;
          state           <= S_OUT;
        end
        S_OUT: begin
          if (!span_stall) begin
            span_valid <= 1'b0;
            if (span.last_row) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + (AW+1)'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/qstb_span_mem.sv
// ----------------------------------------------------------------------------
// Quad span table memory
// One span store of left and right values per row, with registered read.
// ----------------------------------------------------------------------------
module qstb_span_mem import qstb_pkg::*; #(
  parameter int unsigned MAX_ROWS = DefMaxRows
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MAX_ROWS)-1:0]   waddr,
  input  logic signed [CoordBits-1:0]   wleft,
  input  logic signed [CoordBits-1:0]   wright,
  input  logic [$clog2(MAX_ROWS)-1:0]   raddr,
  output logic signed [CoordBits-1:0]   rleft,
  output logic signed [CoordBits-1:0]   rright
);

  logic [2*CoordBits-1:0] mem [MAX_ROWS];
  logic [2*CoordBits-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wleft, wright};
    end
    rdata <= mem[raddr];
  end

  assign rleft  = rdata[2*CoordBits-1:CoordBits];
  assign rright = rdata[CoordBits-1:0];

endmodule
